// File: src/text_console_lcd_command_gen_macros.svh
// Assertion macros shared by the console command generator modules.
// Expects signals named clock and reset in the including module.
`ifndef TEXT_CONSOLE_LCD_COMMAND_GEN_MACROS_SVH
`define TEXT_CONSOLE_LCD_COMMAND_GEN_MACROS_SVH

// Property holds on every edge outside reset.
`define TCLCD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Trigger implies consequence on the next edge.
`define TCLCD_ASSERT_NEXT(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error(msg);

`endif

// File: src/tclcd_pkg.sv
// Types and constants for the text console display command generator.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package tclcd_pkg;

   localparam int LINE_CHARS = 20;
   localparam int COL_W      = $clog2(LINE_CHARS);
   localparam int CURSOR_RESET_INT = 300;

   localparam logic [15:0]      CURSOR_RESET = 16'(CURSOR_RESET_INT);
   localparam logic [COL_W-1:0] COL_RESET    = COL_W'(CURSOR_RESET_INT % LINE_CHARS);
   localparam logic [COL_W-1:0] COL_LAST     = COL_W'(LINE_CHARS - 1);
   localparam logic [COL_W:0]   LINE_STEP    = (COL_W + 1)'(LINE_CHARS);

   localparam logic [3:0] OP_START_LO  = 4'h8;
   localparam logic [3:0] OP_START_HI  = 4'h9;
   localparam logic [3:0] OP_CURSOR_LO = 4'ha;
   localparam logic [3:0] OP_CURSOR_HI = 4'hb;
   localparam logic [3:0] OP_DATA      = 4'hc;

   localparam logic [7:0] CHAR_NUL = 8'h00;
   localparam logic [7:0] CHAR_LF  = 8'h0a;
   localparam logic [7:0] CHAR_CR  = 8'h0d;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DATA,
      ST_NL_CLO,
      ST_NL_CHI,
      ST_CLEAR,
      ST_SC_CLO,
      ST_SC_CHI,
      ST_START_LO,
      ST_START_HI
   } state_type;

   typedef enum logic [2:0] {
      SEL_CHAR,
      SEL_ZERO,
      SEL_CUR_LO,
      SEL_CUR_HI,
      SEL_START_LO,
      SEL_START_HI
   } sel_type;

   typedef struct packed {
      logic    load_char;
      logic    adv_char;
      logic    adv_nl;
      logic    cnt_clear;
      logic    cnt_step;
      logic    scroll;
      sel_type sel;
   } cmd_type;

   typedef struct packed {
      logic is_drop;
      logic is_nl;
      logic col_zero;
      logic clr_done;
   } stat_type;

endpackage

`default_nettype wire

// File: src/tclcd_dp.sv
// Datapath: cursor, column, display start, char latch and clear counter.
// Depends on tclcd_pkg; driven by tclcd_ctrl commands.
`default_nettype none

module tclcd_dp (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [7:0]        req_char_byte,
   input  wire tclcd_pkg::cmd_type  cmd,
   output      tclcd_pkg::stat_type stat,
   output      logic [7:0]        data_byte
);
   import tclcd_pkg::*;

   logic [15:0]      cursor_ff, cursor_in;
   logic [15:0]      start_ff, start_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [COL_W-1:0] cnt_ff, cnt_in;
   logic [7:0]       char_ff, char_in;
   logic [16:0]      inc_sum;
   logic [16:0]      nl_sum;
   logic [COL_W:0]   nl_step;

   assign inc_sum = {1'b0, cursor_ff} + 17'd1;
   assign nl_step = LINE_STEP - {1'b0, col_ff};
   assign nl_sum  = {1'b0, cursor_ff} + 17'(nl_step);

   always_comb begin
      cursor_in = cursor_ff;
      col_in    = col_ff;
      start_in  = start_ff;
      cnt_in    = cnt_ff;
      char_in   = char_ff;
      if (cmd.load_char) begin
         char_in = req_char_byte;
      end
      if (cmd.adv_char) begin
         cursor_in = inc_sum[15:0];
         // column restarts on a line boundary or on address wrap
         if (inc_sum[16] || col_ff == COL_LAST) begin
            col_in = '0;
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end else if (cmd.adv_nl) begin
         cursor_in = nl_sum[15:0];
         // past a wrap the new address is below one line, so it is its own column
         if (nl_sum[16]) begin
            col_in = nl_sum[COL_W-1:0];
         end else begin
            col_in = '0;
         end
      end
      if (cmd.scroll) begin
         start_in = start_ff + 16'(LINE_CHARS);
      end
      if (cmd.cnt_clear) begin
         cnt_in = '0;
      end else if (cmd.cnt_step) begin
         cnt_in = cnt_ff + COL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= CURSOR_RESET;
         col_ff    <= COL_RESET;
         start_ff  <= '0;
         cnt_ff    <= '0;
      end else begin
         cursor_ff <= cursor_in;
         col_ff    <= col_in;
         start_ff  <= start_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
   end

   always_comb begin
      stat.is_drop  = req_char_byte inside {CHAR_NUL, CHAR_CR};
      stat.is_nl    = (req_char_byte == CHAR_LF);
      stat.col_zero = (col_ff == '0);
      stat.clr_done = (cnt_ff == COL_LAST);
   end

   always_comb begin
      case (cmd.sel)
         SEL_CHAR:     data_byte = char_ff;
         SEL_ZERO:     data_byte = 8'h00;
         SEL_CUR_LO:   data_byte = cursor_ff[7:0];
         SEL_CUR_HI:   data_byte = cursor_ff[15:8];
         SEL_START_LO: data_byte = start_ff[7:0];
         SEL_START_HI: data_byte = start_ff[15:8];
         default:      data_byte = 8'h00;
      endcase
   end

`include "text_console_lcd_command_gen_macros.svh"

   `TCLCD_ASSERT(a_col_range, col_ff <= COL_LAST, "column out of range")
   `TCLCD_ASSERT_NEXT(a_nl_aligned, cmd.adv_nl && !nl_sum[16], col_ff == '0, "newline left column")
   `TCLCD_ASSERT_NEXT(a_scroll_step, cmd.scroll, start_ff == $past(start_ff) + 16'(LINE_CHARS),
      "display start did not advance one line")

endmodule

`default_nettype wire

// File: src/tclcd_ctrl.sv
// Controller: sequences the bus writes for each text byte.
// Depends on tclcd_pkg; commands tclcd_dp and reads its status.
`default_nettype none

module tclcd_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_ready,
   output      logic               rsp_valid,
   input  wire logic               rsp_ready,
   output      logic [3:0]         rsp_instruction_code,
   output      logic               rsp_last,
   input  wire tclcd_pkg::stat_type  stat,
   output      tclcd_pkg::cmd_type   cmd
);
   import tclcd_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (stat.is_drop) begin
                  state_in = ST_IDLE;
               end else if (stat.is_nl) begin
                  state_in = stat.col_zero ? ST_IDLE : ST_NL_CLO;
               end else begin
                  state_in = ST_DATA;
               end
            end
         end
         ST_DATA:     if (rsp_ready) state_in = stat.col_zero ? ST_CLEAR : ST_IDLE;
         ST_NL_CLO:   if (rsp_ready) state_in = ST_NL_CHI;
         ST_NL_CHI:   if (rsp_ready) state_in = ST_CLEAR;
         ST_CLEAR:    if (rsp_ready && stat.clr_done) state_in = ST_SC_CLO;
         ST_SC_CLO:   if (rsp_ready) state_in = ST_SC_CHI;
         ST_SC_CHI:   if (rsp_ready) state_in = ST_START_LO;
         ST_START_LO: if (rsp_ready) state_in = ST_START_HI;
         ST_START_HI: if (rsp_ready) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready            = 1'b0;
      rsp_valid            = 1'b1;
      rsp_instruction_code = OP_DATA;
      rsp_last             = 1'b0;
      cmd                  = '0;
      cmd.sel              = SEL_ZERO;
      case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            rsp_valid     = 1'b0;
            cmd.cnt_clear = 1'b1;
            if (req_valid && !stat.is_drop) begin
               cmd.load_char = !stat.is_nl;
               cmd.adv_char  = !stat.is_nl;
               cmd.adv_nl    = stat.is_nl && !stat.col_zero;
            end
         end
         ST_DATA: begin
            cmd.sel  = SEL_CHAR;
            rsp_last = !stat.col_zero;
         end
         ST_NL_CLO, ST_SC_CLO: begin
            rsp_instruction_code = OP_CURSOR_LO;
            cmd.sel              = SEL_CUR_LO;
         end
         ST_NL_CHI: begin
            rsp_instruction_code = OP_CURSOR_HI;
            cmd.sel              = SEL_CUR_HI;
         end
         ST_CLEAR: begin
            cmd.cnt_step = rsp_ready;
         end
         ST_SC_CHI: begin
            rsp_instruction_code = OP_CURSOR_HI;
            cmd.sel              = SEL_CUR_HI;
            // advance the display start before its two beats go out
            cmd.scroll           = rsp_ready;
         end
         ST_START_LO: begin
            rsp_instruction_code = OP_START_LO;
            cmd.sel              = SEL_START_LO;
         end
         ST_START_HI: begin
            rsp_instruction_code = OP_START_HI;
            cmd.sel              = SEL_START_HI;
            rsp_last             = 1'b1;
         end
         default: begin
            rsp_valid = 1'b0;
         end
      endcase
   end

`include "text_console_lcd_command_gen_macros.svh"

   `TCLCD_ASSERT(a_one_side, !(req_ready && rsp_valid), "input taken while a beat is pending")
   `TCLCD_ASSERT_NEXT(a_hold_on_stall, rsp_valid && !rsp_ready, state_ff == $past(state_ff),
      "state moved while beat stalled")
   `TCLCD_ASSERT_NEXT(a_last_ends, rsp_valid && rsp_ready && rsp_last, state_ff == ST_IDLE,
      "last beat did not end the sequence")

endmodule

`default_nettype wire

// File: src/text_console_lcd_command_gen.sv
// Text console display command generator, top level.
// A printable byte gives its data beat in the cycle after acceptance.
// Bus beats go out one per cycle while rsp_ready is high; a dropped byte gives no beat,
// a plain char gives one, and a wrap or newline gives up to 26 beats at 20 columns.
// A new byte is taken only once the last one's beats are done. Synchronous reset sets the
// cursor to 300, display start to 0 and returns the controller to idle.
`default_nettype none

module text_console_lcd_command_gen (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_ready,
   input  wire logic [7:0] req_char_byte,
   output      logic       rsp_valid,
   input  wire logic       rsp_ready,
   output      logic [3:0] rsp_instruction_code,
   output      logic [7:0] rsp_data_byte,
   output      logic       rsp_last
);
   import tclcd_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   tclcd_ctrl u_ctrl (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_instruction_code (rsp_instruction_code),
      .rsp_last             (rsp_last),
      .stat                 (stat),
      .cmd                  (cmd)
   );

   tclcd_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_char_byte (req_char_byte),
      .cmd           (cmd),
      .stat          (stat),
      .data_byte     (rsp_data_byte)
   );

endmodule

`default_nettype wire
